[rtl/mpfb_pkg.sv]
`timescale 1ns / 1ps
package mpfb_pkg;

  // geometry defaults
  localparam int SCREEN_WIDTH_DEF = 128;
  localparam int SCREEN_PAGES_DEF = 8;

  // signed coordinate width for all internal position math
  localparam int CW = 12;

  // command codes
  localparam logic [3:0] CMD_CLEAR   = 4'd0;
  localparam logic [3:0] CMD_PIXEL   = 4'd1;
  localparam logic [3:0] CMD_FILL    = 4'd2;
  localparam logic [3:0] CMD_CHAR    = 4'd3;
  localparam logic [3:0] CMD_BOLD    = 4'd4;
  localparam logic [3:0] CMD_BOLD_Y  = 4'd5;
  localparam logic [3:0] CMD_BCLR_Y  = 4'd6;
  localparam logic [3:0] CMD_CHAR2X  = 4'd7;
  localparam logic [3:0] CMD_SCROLL  = 4'd8;
  localparam logic [3:0] CMD_BAR     = 4'd9;
  localparam logic [3:0] CMD_READ    = 4'd10;

  // glyph code range and substitute
  localparam logic [7:0] CODE_LO   = 8'd32;
  localparam logic [7:0] CODE_HI   = 8'd126;
  localparam logic [7:0] CODE_SUBST = 8'd63;

  // per-command operands handed from the sequencer to the byte datapath
  typedef struct packed {
    logic [3:0]           typ;
    logic                 on;
    logic signed [CW-1:0] xa;
    logic signed [CW-1:0] ya;
    logic signed [CW-1:0] xhi;
    logic signed [CW-1:0] plo;
    logic signed [CW-1:0] alo;
    logic signed [CW-1:0] ahi;
    logic signed [CW-1:0] blo;
    logic signed [CW-1:0] bhi;
    logic signed [CW-1:0] bxlo;
    logic signed [CW-1:0] bxhi;
    logic [4:0][7:0]      glyph;
  } mpfb_op_t;

  function automatic logic signed [CW-1:0] clampc(input logic signed [CW-1:0] v,
                                                  input logic signed [CW-1:0] lo,
                                                  input logic signed [CW-1:0] hi);
    logic signed [CW-1:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

  // 5x7 font, codes 32..126, five columns each, LSB on top
  localparam logic [7:0] FONT [0:474] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00, 8'h00,8'h07,8'h00,8'h07,8'h00,
    8'h14,8'h7F,8'h14,8'h7F,8'h14, 8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
    8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00, 8'h00,8'h1C,8'h22,8'h41,8'h00,
    8'h00,8'h41,8'h22,8'h1C,8'h00, 8'h08,8'h2A,8'h1C,8'h2A,8'h08, 8'h08,8'h08,8'h3E,8'h08,8'h08,
    8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08, 8'h00,8'h60,8'h60,8'h00,8'h00,
    8'h20,8'h10,8'h08,8'h04,8'h02, 8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
    8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31, 8'h18,8'h14,8'h12,8'h7F,8'h10,
    8'h27,8'h45,8'h45,8'h45,8'h39, 8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
    8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E, 8'h00,8'h36,8'h36,8'h00,8'h00,
    8'h00,8'h56,8'h36,8'h00,8'h00, 8'h00,8'h08,8'h14,8'h22,8'h41, 8'h14,8'h14,8'h14,8'h14,8'h14,
    8'h41,8'h22,8'h14,8'h08,8'h00, 8'h02,8'h01,8'h51,8'h09,8'h06, 8'h32,8'h49,8'h79,8'h41,8'h3E,
    8'h7E,8'h11,8'h11,8'h11,8'h7E, 8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
    8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h7F,8'h49,8'h49,8'h49,8'h41, 8'h7F,8'h09,8'h09,8'h01,8'h01,
    8'h3E,8'h41,8'h41,8'h51,8'h32, 8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
    8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41, 8'h7F,8'h40,8'h40,8'h40,8'h40,
    8'h7F,8'h02,8'h04,8'h02,8'h7F, 8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
    8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E, 8'h7F,8'h09,8'h19,8'h29,8'h46,
    8'h46,8'h49,8'h49,8'h49,8'h31, 8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
    8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h7F,8'h20,8'h18,8'h20,8'h7F, 8'h63,8'h14,8'h08,8'h14,8'h63,
    8'h03,8'h04,8'h78,8'h04,8'h03, 8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h00,8'h7F,8'h41,8'h41,
    8'h02,8'h04,8'h08,8'h10,8'h20, 8'h41,8'h41,8'h7F,8'h00,8'h00, 8'h04,8'h02,8'h01,8'h02,8'h04,
    8'h40,8'h40,8'h40,8'h40,8'h40, 8'h00,8'h01,8'h02,8'h04,8'h00, 8'h20,8'h54,8'h54,8'h54,8'h78,
    8'h7F,8'h48,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h20, 8'h38,8'h44,8'h44,8'h48,8'h7F,
    8'h38,8'h54,8'h54,8'h54,8'h18, 8'h08,8'h7E,8'h09,8'h01,8'h02, 8'h08,8'h14,8'h54,8'h54,8'h3C,
    8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h44,8'h7D,8'h40,8'h00, 8'h20,8'h40,8'h44,8'h3D,8'h00,
    8'h00,8'h7F,8'h10,8'h28,8'h44, 8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h18,8'h04,8'h78,
    8'h7C,8'h08,8'h04,8'h04,8'h78, 8'h38,8'h44,8'h44,8'h44,8'h38, 8'h7C,8'h14,8'h14,8'h14,8'h08,
    8'h08,8'h14,8'h14,8'h18,8'h7C, 8'h7C,8'h08,8'h04,8'h04,8'h08, 8'h48,8'h54,8'h54,8'h54,8'h20,
    8'h04,8'h3F,8'h44,8'h40,8'h20, 8'h3C,8'h40,8'h40,8'h20,8'h7C, 8'h1C,8'h20,8'h40,8'h20,8'h1C,
    8'h3C,8'h40,8'h30,8'h40,8'h3C, 8'h44,8'h28,8'h10,8'h28,8'h44, 8'h0C,8'h50,8'h50,8'h50,8'h3C,
    8'h44,8'h64,8'h54,8'h4C,8'h44, 8'h00,8'h08,8'h36,8'h41,8'h00, 8'h00,8'h00,8'h7F,8'h00,8'h00,
    8'h00,8'h41,8'h36,8'h08,8'h00, 8'h08,8'h04,8'h08,8'h10,8'h08
  };

endpackage

[rtl/mpfb_ram.sv]
`timescale 1ns / 1ps
module mpfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/mpfb_byte_alu.sv]
`timescale 1ns / 1ps
module mpfb_byte_alu (
  input  mpfb_pkg::mpfb_op_t          op,
  input  logic signed [mpfb_pkg::CW-1:0] x,
  input  logic signed [mpfb_pkg::CW-1:0] p,
  input  logic [7:0]                  old_byte,
  input  logic [7:0]                  nb_byte,
  output logic [7:0]                  new_byte
);
  import mpfb_pkg::*;

  logic signed [CW-1:0] c;
  logic signed [CW-1:0] row0;
  logic [7:0]           g0, g1, gpair, g2x;
  logic [7:0]           ma, mb, gm, bgm;
  logic [15:0]          e;

  // glyph column at a signed offset, zero outside the five columns
  function automatic logic [7:0] gsel(input logic [4:0][7:0] g,
                                      input logic signed [CW-1:0] k);
    logic [7:0] r;
    r = 8'h00;
    if (k >= 0 && k <= 4) r = g[k[2:0]];
    return r;
  endfunction

  // row mask of one page against an inclusive row range
  function automatic logic [7:0] rmask(input logic signed [CW-1:0] r0,
                                       input logic signed [CW-1:0] lo,
                                       input logic signed [CW-1:0] hi);
    logic [7:0]           m;
    logic signed [CW-1:0] y;
    for (int b = 0; b < 8; b++) begin
      y = r0 + CW'(b);
      m[b] = (y >= lo) && (y <= hi);
    end
    return m;
  endfunction

  always_comb begin
    c     = x - op.xa;
    row0  = p <<< 3;
    g0    = gsel(op.glyph, c);
    g1    = gsel(op.glyph, c - CW'(1));
    gpair = g0 | g1;
    g2x   = gsel(op.glyph, c >>> 1);
    ma    = rmask(row0, op.alo, op.ahi);
    mb    = rmask(row0, op.blo, op.bhi);
    bgm   = (x >= op.bxlo && x <= op.bxhi) ? ma : 8'h00;

    // glyph pixels placed at a free row offset
    for (int b = 0; b < 8; b++) begin
      logic signed [CW-1:0] d;
      d = row0 + CW'(b) - op.ya;
      gm[b] = (d >= 0 && d <= 6) ? gpair[d[2:0]] : 1'b0;
    end

    // doubled glyph column, two bits per source pixel
    for (int b = 0; b < 8; b++) begin
      e[2*b]   = g2x[b];
      e[2*b+1] = g2x[b];
    end

    unique case (op.typ)
      CMD_CLEAR:  new_byte = 8'h00;
      CMD_PIXEL:  new_byte = op.on ? (old_byte | ma) : (old_byte & ~ma);
      CMD_FILL:   new_byte = old_byte | ma;
      CMD_CHAR:   new_byte = g0;
      CMD_BOLD:   new_byte = (c == CW'(6)) ? 8'h00 : (old_byte | gpair);
      CMD_BOLD_Y: new_byte = old_byte | gm;
      CMD_BCLR_Y: new_byte = (old_byte | bgm) & ~gm;
      CMD_CHAR2X: new_byte = (p == op.plo) ? e[7:0] : e[15:8];
      CMD_SCROLL: new_byte = (old_byte & ~ma) | ((x < op.xhi) ? (nb_byte & ma) : 8'h00);
      CMD_BAR:    new_byte = (old_byte & ~ma) | mb;
      default:    new_byte = old_byte;
    endcase
  end

endmodule

[rtl/mono_page_framebuffer_draw_engine.sv]
`timescale 1ns / 1ps
// Monochrome page framebuffer drawing engine.
// Input stream: one drawing command per transaction; in_tuser carries the
// command code, in_tdata its operands. Output stream: one result per command,
// out_tuser echoes the code, out_tdata holds the byte read (zero otherwise).
// Commands run one at a time against a single frame memory
// (SCREEN_WIDTH*SCREEN_PAGES bytes, registered read). Each touched byte is a
// read then a write, with a neighbor read in between for scroll. Bytes
// per command: pixel/bar a few bytes, glyphs 6 to 24 bytes (a wide bold
// clear background up to two full pages), a full clear every byte.
// Read commands and empty or fully clipped commands write no bytes.
// After reset a clearing pass writes zero to every byte, one per cycle;
// in_tready stays low during it.
// in_tready is high whenever no command is in work; a finished result waits in
// the output register, and the next command may start meanwhile. A stalled
// receiver blocks only the completion of the command after that.
module mono_page_framebuffer_draw_engine #(
  parameter int SCREEN_WIDTH = mpfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_PAGES = mpfb_pkg::SCREEN_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // x_a[8:0] y_a[17:9] x_b[26:18] y_b[35:27] page[40:36] page_last[45:41]
  // char_code[53:46] pixel_on[54] level[62:55] read_index[72:63], rest zero
  input  logic [79:0] in_tdata,
  input  logic [3:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // read_data
  output logic [3:0]  out_tuser   // req_echo
);
  import mpfb_pkg::*;

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(SCREEN_WIDTH);
  localparam int PW    = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;

  localparam logic signed [CW-1:0] WS = CW'(SCREEN_WIDTH);
  localparam logic signed [CW-1:0] HS = CW'(8 * SCREEN_PAGES);
  localparam logic signed [CW-1:0] PS = CW'(SCREEN_PAGES);
  localparam logic signed [CW-1:0] C0 = '0;
  localparam logic signed [CW-1:0] C1 = CW'(1);
  localparam logic signed [CW-1:0] M1 = -CW'(1);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_NB   = 3'd3;
  localparam logic [2:0] ST_WR   = 3'd4;
  localparam logic [2:0] ST_RDD  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]    state_r;
  logic [AW-1:0] clr_r;
  mpfb_op_t      op_r, op_nxt;
  logic [XW-1:0] x_r, xlo_r, xhi_r;
  logic [PW-1:0] p_r, phi_r;
  logic [7:0]    old_r, rd_r;
  logic          out_valid_r;
  logic [7:0]    out_data_r;
  logic [3:0]    out_user_r;

  // field unpack
  logic signed [CW-1:0] xa, ya, xb, yb, pg, pl, lvl;
  logic [7:0]           code, code_m;
  logic [9:0]           ridx;
  logic [8:0]           base;

  // command window
  logic signed [CW-1:0] wxlo, wxhi, wplo, wphi, y0, y1, t, hgt, bar;
  logic                 wempty;

  logic                 accept, rd_ok;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr, addr_cur;
  logic [7:0]           ram_wdata, ram_rdata, alu_old, alu_new;
  logic                 last_x, last_p;

  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    xa   = CW'($signed(in_tdata[8:0]));
    ya   = CW'($signed(in_tdata[17:9]));
    xb   = CW'($signed(in_tdata[26:18]));
    yb   = CW'($signed(in_tdata[35:27]));
    pg   = CW'($signed(in_tdata[40:36]));
    pl   = CW'($signed(in_tdata[45:41]));
    code = in_tdata[53:46];
    lvl  = CW'({1'b0, in_tdata[62:55]});
    ridx = in_tdata[72:63];
    rd_ok = {3'b000, ridx} < 13'(DEPTH);
    code_m = (code < CODE_LO || code > CODE_HI) ? CODE_SUBST : code;
    base = 9'(({1'b0, code_m} - 9'd32) * 9'd5);
  end

  // decode a command into a byte window and datapath operands
  always_comb begin
    op_nxt       = '0;
    op_nxt.typ   = in_tuser;
    op_nxt.on    = in_tdata[54];
    op_nxt.xa    = xa;
    op_nxt.ya    = ya;
    op_nxt.bxlo  = C1;
    op_nxt.bxhi  = C0;
    op_nxt.alo   = C1;
    op_nxt.ahi   = C0;
    op_nxt.blo   = C1;
    op_nxt.bhi   = C0;
    for (int i = 0; i < 5; i++) begin
      op_nxt.glyph[i] = FONT[base + 9'(i)];
    end
    wxlo = C0; wxhi = C0; wplo = C0; wphi = C0; wempty = 1'b1;
    y0 = C0; y1 = C0; t = C0;
    hgt = yb - ya + C1;
    bar = (lvl > hgt) ? hgt : lvl;
    unique case (in_tuser)
      CMD_CLEAR: begin
        wplo = clampc(pg, C0, PS);
        wphi = clampc(pl, M1, PS - C1);
        wxhi = WS - C1;
        wempty = wplo > wphi;
      end
      CMD_PIXEL: begin
        wxlo = xa; wxhi = xa;
        wplo = ya >>> 3; wphi = ya >>> 3;
        op_nxt.alo = ya; op_nxt.ahi = ya;
        wempty = !(xa >= C0 && xa < WS && ya >= C0 && ya < HS);
      end
      CMD_FILL, CMD_SCROLL: begin
        wxlo = clampc(xa, C0, WS);
        wxhi = clampc(xb, M1, WS - C1);
        y0 = clampc(ya, C0, HS);
        y1 = clampc(yb, M1, HS - C1);
        wplo = y0 >>> 3; wphi = y1 >>> 3;
        op_nxt.alo = y0; op_nxt.ahi = y1;
        wempty = (wxlo > wxhi) || (y0 > y1);
      end
      CMD_CHAR, CMD_BOLD: begin
        wxlo = clampc(xa, C0, WS);
        wxhi = clampc(xa + ((in_tuser == CMD_CHAR) ? CW'(5) : CW'(6)), M1, WS - C1);
        wplo = pg; wphi = pg;
        wempty = (pg < C0) || (pg >= PS) || (wxlo > wxhi);
      end
      CMD_BOLD_Y: begin
        wxlo = clampc(xa, C0, WS);
        wxhi = clampc(xa + CW'(5), M1, WS - C1);
        y0 = clampc(ya, C0, HS);
        y1 = clampc(ya + CW'(6), M1, HS - C1);
        wplo = y0 >>> 3; wphi = y1 >>> 3;
        wempty = (wxlo > wxhi) || (y0 > y1);
      end
      CMD_BCLR_Y: begin
        op_nxt.bxlo = clampc(xa - C1, C0, WS);
        op_nxt.bxhi = clampc(xa + xb - C1, M1, WS - C1);
        y0 = clampc(ya - C1, C0, HS);
        y1 = clampc(ya + CW'(7), M1, HS - C1);
        op_nxt.alo = y0; op_nxt.ahi = y1;
        t = (xa + xb - C1 > xa + CW'(5)) ? (xa + xb - C1) : (xa + CW'(5));
        wxlo = op_nxt.bxlo;
        wxhi = clampc(t, M1, WS - C1);
        wplo = y0 >>> 3; wphi = y1 >>> 3;
        wempty = (wxlo > wxhi) || (y0 > y1);
      end
      CMD_CHAR2X: begin
        wxlo = clampc(xa, C0, WS);
        wxhi = clampc(xa + CW'(11), M1, WS - C1);
        wplo = pg; wphi = pg + C1;
        wempty = (pg < C0) || (pg + C1 >= PS) || (wxlo > wxhi);
      end
      CMD_BAR: begin
        wxlo = xa; wxhi = xa;
        y0 = clampc(ya, C0, HS);
        y1 = clampc(yb, M1, HS - C1);
        wplo = y0 >>> 3; wphi = y1 >>> 3;
        op_nxt.alo = y0; op_nxt.ahi = y1;
        op_nxt.blo = yb - bar + C1; op_nxt.bhi = yb;
        wempty = (xa < C0) || (xa >= WS) || (y0 > y1);
      end
      default: wempty = 1'b1;
    endcase
    op_nxt.xhi = wxhi;
    op_nxt.plo = wplo;
  end

  // byte address and loop ends
  assign addr_cur = AW'(AW'(p_r) * AW'(SCREEN_WIDTH) + AW'(x_r));
  assign last_x   = (x_r == xhi_r);
  assign last_p   = (p_r == phi_r);

  always_comb begin
    ram_raddr = addr_cur;
    if (state_r == ST_IDLE) begin
      ram_raddr = AW'(ridx);
    end else if (state_r == ST_RD && op_r.typ == CMD_SCROLL) begin
      ram_raddr = addr_cur;
    end else if (state_r == ST_NB) begin
      ram_raddr = last_x ? addr_cur : AW'(addr_cur + AW'(1));
    end
  end

  assign alu_old   = (op_r.typ == CMD_SCROLL) ? old_r : ram_rdata;
  assign ram_we    = (state_r == ST_CLR) || (state_r == ST_WR);
  assign ram_waddr = (state_r == ST_CLR) ? clr_r : addr_cur;
  assign ram_wdata = (state_r == ST_CLR) ? 8'h00 : alu_new;

  mpfb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mpfb_byte_alu u_alu (
    .op       (op_r),
    .x        (CW'({1'b0, x_r})),
    .p        (CW'({1'b0, p_r})),
    .old_byte (alu_old),
    .nb_byte  (ram_rdata),
    .new_byte (alu_new)
  );

  // sequencer: clear pass, then per-command byte walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result taken; a completing command reloads the register below
      if (out_valid_r && out_tready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_r  <= op_nxt;
            rd_r  <= 8'h00;
            x_r   <= XW'(wxlo);
            xlo_r <= XW'(wxlo);
            xhi_r <= XW'(wxhi);
            p_r   <= PW'(wplo);
            phi_r <= PW'(wphi);
            if (in_tuser == CMD_READ) begin
              state_r <= rd_ok ? ST_RDD : ST_DONE;
            end else if (wempty) begin
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state_r <= (op_r.typ == CMD_SCROLL) ? ST_NB : ST_WR;
        end
        ST_NB: begin
          old_r   <= ram_rdata;
          state_r <= ST_WR;
        end
        ST_WR: begin
          if (last_x) begin
            x_r <= xlo_r;
            if (last_p) begin
              state_r <= ST_DONE;
            end else begin
              p_r     <= p_r + PW'(1);
              state_r <= ST_RD;
            end
          end else begin
            x_r     <= x_r + XW'(1);
            state_r <= ST_RD;
          end
        end
        ST_RDD: begin
          rd_r    <= ram_rdata;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= rd_r;
            out_user_r  <= op_r.typ;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
